>>> rtl/cpu_condition_code_unit_assert.svh
// ----------------------------------------------------------------------------
// Condition code unit assertion macros
// Macros for concurrent checks on the clk domain with an arst_n disable.
// ----------------------------------------------------------------------------
`ifndef CPU_CONDITION_CODE_UNIT_ASSERT_SVH
`define CPU_CONDITION_CODE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define CCU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CCU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CCU_ASSERT_NOW(label, ante, cons, msg)
`define CCU_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> rtl/ccu_pkg.sv
// ----------------------------------------------------------------------------
// Condition code unit package
// Shared types, operand constants and code enumerations.
// ----------------------------------------------------------------------------
package ccu_pkg;

	localparam int unsigned DataWidth = 32;
	localparam int unsigned CountWidth = 6;
	localparam int unsigned FlagWidth = 5;

	localparam logic [DataWidth-1:0] MaskByte = 32'h0000_00ff;
	localparam logic [DataWidth-1:0] MaskWord = 32'h0000_ffff;
	localparam logic [DataWidth-1:0] MaskLong = 32'hffff_ffff;
	localparam logic [DataWidth-1:0] TopByte = 32'h0000_0080;
	localparam logic [DataWidth-1:0] TopWord = 32'h0000_8000;
	localparam logic [DataWidth-1:0] TopLong = 32'h8000_0000;
	localparam logic [4:0] MsbByte = 5'd7;
	localparam logic [4:0] MsbWord = 5'd15;
	localparam logic [4:0] MsbLong = 5'd31;

	typedef struct packed {
		logic x;
		logic n;
		logic z;
		logic v;
		logic c;
	} flags_t;

	typedef enum logic [1:0] {
		OP_UPDATE = 2'd0,
		OP_TEST   = 2'd1,
		OP_LOAD   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		SIZE_BYTE = 2'd0,
		SIZE_WORD = 2'd1,
		SIZE_LONG = 2'd2
	} size_t;

	typedef enum logic {
		X_KEEP  = 1'b0,
		X_CARRY = 1'b1
	} x_rule_t;

	typedef enum logic [1:0] {
		N_KEEP   = 2'd0,
		N_SIGN   = 2'd1,
		N_INVERT = 2'd2
	} n_rule_t;

	typedef enum logic [1:0] {
		Z_KEEP   = 2'd0,
		Z_ZERO   = 2'd1,
		Z_INVERT = 2'd2,
		Z_STICKY = 2'd3
	} z_rule_t;

	typedef enum logic [2:0] {
		V_KEEP     = 3'd0,
		V_CLEAR    = 3'd1,
		V_INVERT   = 3'd2,
		V_ADD_OVF  = 3'd3,
		V_SUB_OVF  = 3'd4,
		V_DEST_RES = 3'd5
	} v_rule_t;

	typedef enum logic [3:0] {
		C_KEEP     = 4'd0,
		C_INVERT   = 4'd1,
		C_CLEAR    = 4'd2,
		C_COPY_X   = 4'd3,
		C_SHR_OUT  = 4'd4,
		C_SHL_OUT  = 4'd5,
		C_SIGNS_OR = 4'd6,
		C_BORROW   = 4'd7,
		C_CARRY    = 4'd8
	} c_rule_t;

	typedef enum logic [3:0] {
		CC_T  = 4'd0,
		CC_F  = 4'd1,
		CC_HI = 4'd2,
		CC_LS = 4'd3,
		CC_CC = 4'd4,
		CC_CS = 4'd5,
		CC_NE = 4'd6,
		CC_EQ = 4'd7,
		CC_VC = 4'd8,
		CC_VS = 4'd9,
		CC_PL = 4'd10,
		CC_MI = 4'd11,
		CC_GE = 4'd12,
		CC_LT = 4'd13,
		CC_GT = 4'd14,
		CC_LE = 4'd15
	} cond_t;

endpackage

>>> rtl/ccu_flag_update.sv
// ----------------------------------------------------------------------------
// Condition code flag update
// Computes the next flag set from the old flags and one registered item.
// ----------------------------------------------------------------------------
module ccu_flag_update (
	input  logic [1:0]                     op,
	input  logic [1:0]                     size,
	input  logic                           x_rule,
	input  logic [1:0]                     n_rule,
	input  logic [1:0]                     z_rule,
	input  logic [2:0]                     v_rule,
	input  logic [3:0]                     c_rule,
	input  logic [ccu_pkg::DataWidth-1:0]  source,
	input  logic [ccu_pkg::DataWidth-1:0]  dest,
	input  logic [ccu_pkg::DataWidth-1:0]  result_value,
	input  logic [ccu_pkg::CountWidth-1:0] shift_count,
	input  ccu_pkg::flags_t                flags_old,
	output ccu_pkg::flags_t                flags_new
);

	logic [ccu_pkg::DataWidth-1:0] mask;
	logic [ccu_pkg::DataWidth-1:0] top;
	logic [4:0] msb;
	logic [ccu_pkg::DataWidth-1:0] s;
	logic [ccu_pkg::DataWidth-1:0] d;
	logic [ccu_pkg::DataWidth-1:0] r;
	logic sm;
	logic dm;
	logic rm;
	logic r_zero;
	logic cnt_ok;
	logic [ccu_pkg::CountWidth-1:0] shr_idx;
	logic [ccu_pkg::CountWidth-1:0] shl_idx;
	ccu_pkg::flags_t upd;

	always_comb begin
		unique case (ccu_pkg::size_t'(size))
			ccu_pkg::SIZE_BYTE: begin
				mask = ccu_pkg::MaskByte;
				top  = ccu_pkg::TopByte;
				msb  = ccu_pkg::MsbByte;
			end
			ccu_pkg::SIZE_WORD: begin
				mask = ccu_pkg::MaskWord;
				top  = ccu_pkg::TopWord;
				msb  = ccu_pkg::MsbWord;
			end
			default: begin
				mask = ccu_pkg::MaskLong;
				top  = ccu_pkg::TopLong;
				msb  = ccu_pkg::MsbLong;
			end
		endcase
	end

	assign s      = source & mask;
	assign d      = dest & mask;
	assign r      = result_value & mask;
	assign sm     = |(s & top);
	assign dm     = |(d & top);
	assign rm     = |(r & top);
	assign r_zero = (r == '0);

	assign cnt_ok  = (shift_count != '0) && (shift_count <= ({1'b0, msb} + 6'd1));
	assign shr_idx = shift_count - 6'd1;
	assign shl_idx = {1'b0, msb} + 6'd1 - shift_count;

	always_comb begin
		upd = flags_old;

		unique case (ccu_pkg::n_rule_t'(n_rule))
			ccu_pkg::N_SIGN:   upd.n = rm;
			ccu_pkg::N_INVERT: upd.n = ~flags_old.n;
			default:           upd.n = flags_old.n;
		endcase

		unique case (ccu_pkg::z_rule_t'(z_rule))
			ccu_pkg::Z_ZERO:   upd.z = r_zero;
			ccu_pkg::Z_INVERT: upd.z = ~flags_old.z;
			ccu_pkg::Z_STICKY: upd.z = flags_old.z & r_zero;
			default:           upd.z = flags_old.z;
		endcase

		unique case (ccu_pkg::v_rule_t'(v_rule))
			ccu_pkg::V_CLEAR:    upd.v = 1'b0;
			ccu_pkg::V_INVERT:   upd.v = ~flags_old.v;
			ccu_pkg::V_ADD_OVF:  upd.v = (sm & dm & ~rm) | (~sm & ~dm & rm);
			ccu_pkg::V_SUB_OVF:  upd.v = (~sm & dm & ~rm) | (sm & ~dm & rm);
			ccu_pkg::V_DEST_RES: upd.v = dm & rm;
			default:             upd.v = flags_old.v;
		endcase

		unique case (ccu_pkg::c_rule_t'(c_rule))
			ccu_pkg::C_INVERT:   upd.c = ~flags_old.c;
			ccu_pkg::C_CLEAR:    upd.c = 1'b0;
			ccu_pkg::C_COPY_X:   upd.c = flags_old.x;
			ccu_pkg::C_SHR_OUT:  upd.c = cnt_ok & d[shr_idx[4:0]];
			ccu_pkg::C_SHL_OUT:  upd.c = cnt_ok & d[shl_idx[4:0]];
			ccu_pkg::C_SIGNS_OR: upd.c = dm | rm;
			ccu_pkg::C_BORROW:   upd.c = (sm & ~dm) | (rm & ~dm) | (sm & rm);
			ccu_pkg::C_CARRY:    upd.c = (sm & dm) | (~rm & dm) | (sm & ~rm);
			default:             upd.c = flags_old.c;
		endcase

		if (ccu_pkg::x_rule_t'(x_rule) == ccu_pkg::X_CARRY) begin
			upd.x = upd.c;
		end
	end

	always_comb begin
		unique case (op)
			ccu_pkg::OP_UPDATE: flags_new = upd;
			ccu_pkg::OP_LOAD:   flags_new = ccu_pkg::flags_t'(source[ccu_pkg::FlagWidth-1:0]);
			default:            flags_new = flags_old;
		endcase
	end

endmodule

>>> rtl/ccu_cond_eval.sv
// ----------------------------------------------------------------------------
// Condition code evaluator
// Evaluates one of the sixteen branch conditions on a flag set.
// ----------------------------------------------------------------------------
module ccu_cond_eval (
	input  ccu_pkg::flags_t flags_in,
	input  logic [3:0]      condition,
	output logic            condition_true
);

	always_comb begin
		unique case (ccu_pkg::cond_t'(condition))
			ccu_pkg::CC_T:  condition_true = 1'b1;
			ccu_pkg::CC_F:  condition_true = 1'b0;
			ccu_pkg::CC_HI: condition_true = ~flags_in.c & ~flags_in.z;
			ccu_pkg::CC_LS: condition_true = flags_in.c | flags_in.z;
			ccu_pkg::CC_CC: condition_true = ~flags_in.c;
			ccu_pkg::CC_CS: condition_true = flags_in.c;
			ccu_pkg::CC_NE: condition_true = ~flags_in.z;
			ccu_pkg::CC_EQ: condition_true = flags_in.z;
			ccu_pkg::CC_VC: condition_true = ~flags_in.v;
			ccu_pkg::CC_VS: condition_true = flags_in.v;
			ccu_pkg::CC_PL: condition_true = ~flags_in.n;
			ccu_pkg::CC_MI: condition_true = flags_in.n;
			ccu_pkg::CC_GE: condition_true = ~(flags_in.n ^ flags_in.v);
			ccu_pkg::CC_LT: condition_true = flags_in.n ^ flags_in.v;
			ccu_pkg::CC_GT: condition_true = ~(flags_in.n ^ flags_in.v) & ~flags_in.z;
			default:        condition_true = (flags_in.n ^ flags_in.v) | flags_in.z;
		endcase
	end

endmodule

>>> rtl/cpu_condition_code_unit.sv
// ----------------------------------------------------------------------------
// Condition code unit
// Holds the X, N, Z, V and C flags, updates or loads them per item and
// evaluates a branch condition on the result.
// ----------------------------------------------------------------------------
// The unit accepts one item in every cycle unless back-pressure stalls it, and
// returns one result per item. An accepted item lands in the input register,
// and its flags and condition are computed from it and stored in the result
// register together with the flag register when the input register advances.
// The flag register feeds back into the next item without a bubble.
// Back-pressure on the result side stalls the input register, and input ready
// drops only when both registers are full and the waiting result is not taken.
// After reset all flags are zero.
module cpu_condition_code_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     op,
	input  logic [1:0]                     size,
	input  logic                           x_rule,
	input  logic [1:0]                     n_rule,
	input  logic [1:0]                     z_rule,
	input  logic [2:0]                     v_rule,
	input  logic [3:0]                     c_rule,
	input  logic [ccu_pkg::DataWidth-1:0]  source,
	input  logic [ccu_pkg::DataWidth-1:0]  dest,
	input  logic [ccu_pkg::DataWidth-1:0]  result_value,
	input  logic [ccu_pkg::CountWidth-1:0] shift_count,
	input  logic [3:0]                     condition,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ccu_pkg::FlagWidth-1:0]  flags,
	output logic                           condition_true
);

	`include "cpu_condition_code_unit_assert.svh"

	logic                           valid_s1;
	logic [1:0]                     op_s1;
	logic [1:0]                     size_s1;
	logic                           x_rule_s1;
	logic [1:0]                     n_rule_s1;
	logic [1:0]                     z_rule_s1;
	logic [2:0]                     v_rule_s1;
	logic [3:0]                     c_rule_s1;
	logic [ccu_pkg::DataWidth-1:0]  source_s1;
	logic [ccu_pkg::DataWidth-1:0]  dest_s1;
	logic [ccu_pkg::DataWidth-1:0]  result_s1;
	logic [ccu_pkg::CountWidth-1:0] count_s1;
	logic [3:0]                     cond_s1;

	ccu_pkg::flags_t flag_q;
	ccu_pkg::flags_t flags_next;
	logic            cond_next;
	logic            out_valid_q;
	ccu_pkg::flags_t flags_q;
	logic            cond_q;
	logic            advance;
	logic            in_xfer;

	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;
	assign in_xfer  = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1     <= op;
			size_s1   <= size;
			x_rule_s1 <= x_rule;
			n_rule_s1 <= n_rule;
			z_rule_s1 <= z_rule;
			v_rule_s1 <= v_rule;
			c_rule_s1 <= c_rule;
			source_s1 <= source;
			dest_s1   <= dest;
			result_s1 <= result_value;
			count_s1  <= shift_count;
			cond_s1   <= condition;
		end
	end

	ccu_flag_update u_flag_update (
		.op           (op_s1),
		.size         (size_s1),
		.x_rule       (x_rule_s1),
		.n_rule       (n_rule_s1),
		.z_rule       (z_rule_s1),
		.v_rule       (v_rule_s1),
		.c_rule       (c_rule_s1),
		.source       (source_s1),
		.dest         (dest_s1),
		.result_value (result_s1),
		.shift_count  (count_s1),
		.flags_old    (flag_q),
		.flags_new    (flags_next)
	);

	ccu_cond_eval u_cond_eval (
		.flags_in       (flags_next),
		.condition      (cond_s1),
		.condition_true (cond_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				flag_q <= flags_next;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			flags_q <= flags_next;
			cond_q  <= cond_next;
		end
	end

	assign out_valid      = out_valid_q;
	assign flags          = flags_q;
	assign condition_true = cond_q;

	`CCU_ASSERT_NOW(a_out_matches_state, out_valid_q, flags_q == flag_q, "result flags differ from flag register")
	`CCU_ASSERT_NOW(a_ready_only_on_stall, !in_ready, valid_s1 && out_valid_q && !out_ready, "input stalled without output back-pressure")
	`CCU_ASSERT_NEXT(a_test_keeps_flags, advance && (op_s1 == ccu_pkg::OP_TEST), flag_q == $past(flag_q), "test item changed the flags")
	`CCU_ASSERT_NEXT(a_load_writes_flags, advance && (op_s1 == ccu_pkg::OP_LOAD), flag_q == $past(source_s1[ccu_pkg::FlagWidth-1:0]), "load item did not write the flags")

endmodule

>>> bench/tb_cpu_condition_code_unit.sv
// ----------------------------------------------------------------------------
// Condition code unit testbench
// Drives update, test and load transfers into the unit and checks each
// returned flag set and condition bit against table values or an in-bench
// predictor. A directed table covers extremes and corner rules, then random
// rule mixes run with idle bursts on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_cpu_condition_code_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ccu_pkg::*;

	localparam logic [1:0] OpUnused = 2'd3;
	localparam logic [1:0] SizeUnused = 2'd3;
	localparam logic [1:0] NRuleUnused = 2'd3;
	localparam logic [2:0] VRuleUnused = 3'd7;
	localparam logic [3:0] CRuleUnused = 4'd15;

	localparam int DirectedCount = 25;
	localparam int RandomCount = 2000;
	localparam int CalmTail = 300;
	localparam int StallAfter = 800;
	localparam int StallCycles = 120;
	localparam int WatchdogLimit = 2000;

	typedef struct packed {
		logic [1:0]  op;
		logic [1:0]  size;
		logic        x_rule;
		logic [1:0]  n_rule;
		logic [1:0]  z_rule;
		logic [2:0]  v_rule;
		logic [3:0]  c_rule;
		logic [31:0] source;
		logic [31:0] dest;
		logic [31:0] result_value;
		logic [5:0]  shift_count;
		logic [3:0]  condition;
	} ccu_item_t;

	typedef struct packed {
		ccu_item_t  item;
		logic       known;
		logic [4:0] flags;
		logic       cond;
	} ccu_row_t;

	typedef struct packed {
		logic [4:0] flags;
		logic       cond;
	} ccu_result_t;

	localparam ccu_row_t DirectedSteps [0:DirectedCount-1] = '{
		'{'{OP_TEST, SIZE_BYTE, X_KEEP, N_KEEP, Z_KEEP, V_KEEP, C_KEEP,
			32'h0, 32'h0, 32'h0, 6'd0, CC_T}, 1'b1, 5'h00, 1'b1},
		'{'{OP_TEST, SIZE_BYTE, X_KEEP, N_KEEP, Z_KEEP, V_KEEP, C_KEEP,
			32'h0, 32'h0, 32'h0, 6'd0, CC_F}, 1'b1, 5'h00, 1'b0},
		'{'{OP_TEST, SIZE_BYTE, X_KEEP, N_KEEP, Z_KEEP, V_KEEP, C_KEEP,
			32'h0, 32'h0, 32'h0, 6'd0, CC_HI}, 1'b1, 5'h00, 1'b1},
		'{'{OP_LOAD, SIZE_LONG, X_CARRY, N_INVERT, Z_STICKY, V_DEST_RES, C_CARRY,
			32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 6'd63, CC_LE}, 1'b1, 5'h1f, 1'b1},
		'{'{OP_TEST, SIZE_LONG, X_KEEP, N_KEEP, Z_KEEP, V_KEEP, C_KEEP,
			32'h0, 32'h0, 32'h0, 6'd0, CC_GT}, 1'b1, 5'h1f, 1'b0},
		'{'{OpUnused, SIZE_LONG, X_CARRY, N_SIGN, Z_ZERO, V_CLEAR, C_CLEAR,
			32'h0, 32'h0, 32'h0, 6'd0, CC_CS}, 1'b1, 5'h1f, 1'b1},
		'{'{OP_LOAD, SIZE_BYTE, X_KEEP, N_KEEP, Z_KEEP, V_KEEP, C_KEEP,
			32'h0000_ffe0, 32'h0, 32'h0, 6'd0, CC_EQ}, 1'b1, 5'h00, 1'b0},
		'{'{OP_UPDATE, SIZE_LONG, X_CARRY, N_SIGN, Z_ZERO, V_CLEAR, C_CLEAR,
			32'hffff_ffff, 32'hffff_ffff, 32'h0, 6'd0, CC_EQ}, 1'b1, 5'h04, 1'b1},
		'{'{OP_UPDATE, SIZE_BYTE, X_CARRY, N_SIGN, Z_ZERO, V_ADD_OVF, C_CARRY,
			32'h0000_007f, 32'h0000_0001, 32'h0000_0080, 6'd0, CC_VS}, 1'b0, 5'h00, 1'b0},
		'{'{OP_UPDATE, SIZE_WORD, X_CARRY, N_SIGN, Z_ZERO, V_SUB_OVF, C_BORROW,
			32'h0000_0001, 32'h0000_8000, 32'h0000_7fff, 6'd0, CC_LT}, 1'b0, 5'h00, 1'b0},
		'{'{OP_UPDATE, SIZE_LONG, X_CARRY, N_SIGN, Z_STICKY, V_ADD_OVF, C_CARRY,
			32'h8000_0000, 32'h8000_0000, 32'h0, 6'd0, CC_LS}, 1'b0, 5'h00, 1'b0},
		'{'{OP_UPDATE, SIZE_LONG, X_CARRY, N_KEEP, Z_KEEP, V_KEEP, C_SHR_OUT,
			32'h0, 32'hffff_ffff, 32'h0, 6'd0, CC_CS}, 1'b0, 5'h00, 1'b0},
		'{'{OP_UPDATE, SIZE_BYTE, X_CARRY, N_KEEP, Z_KEEP, V_KEEP, C_SHR_OUT,
			32'h0, 32'hffff_ff01, 32'h0, 6'd1, CC_CS}, 1'b0, 5'h00, 1'b0},
		'{'{OP_UPDATE, SIZE_BYTE, X_KEEP, N_KEEP, Z_KEEP, V_KEEP, C_SHR_OUT,
			32'h0, 32'h0000_0080, 32'h0, 6'd8, CC_CC}, 1'b0, 5'h00, 1'b0},
		'{'{OP_UPDATE, SIZE_BYTE, X_CARRY, N_KEEP, Z_KEEP, V_KEEP, C_SHR_OUT,
			32'h0, 32'hffff_ffff, 32'h0, 6'd9, CC_CS}, 1'b0, 5'h00, 1'b0},
		'{'{OP_UPDATE, SIZE_LONG, X_CARRY, N_KEEP, Z_KEEP, V_KEEP, C_SHL_OUT,
			32'h0, 32'h0000_0001, 32'h0, 6'd32, CC_CS}, 1'b0, 5'h00, 1'b0},
		'{'{OP_UPDATE, SIZE_LONG, X_KEEP, N_KEEP, Z_KEEP, V_KEEP, C_SHL_OUT,
			32'h0, 32'hffff_ffff, 32'h0, 6'd33, CC_CC}, 1'b0, 5'h00, 1'b0},
		'{'{OP_UPDATE, SIZE_WORD, X_CARRY, N_KEEP, Z_KEEP, V_KEEP, C_SHL_OUT,
			32'h0, 32'h0000_ffff, 32'h0, 6'd63, CC_CS}, 1'b0, 5'h00, 1'b0},
		'{'{OP_UPDATE, SIZE_BYTE, X_KEEP, N_KEEP, Z_STICKY, V_KEEP, C_KEEP,
			32'h0, 32'h0, 32'h0000_0100, 6'd0, CC_EQ}, 1'b0, 5'h00, 1'b0},
		'{'{OP_UPDATE, SIZE_WORD, X_KEEP, N_KEEP, Z_STICKY, V_KEEP, C_KEEP,
			32'h0, 32'h0, 32'h0000_0100, 6'd0, CC_NE}, 1'b0, 5'h00, 1'b0},
		'{'{OP_UPDATE, SIZE_BYTE, X_CARRY, N_INVERT, Z_INVERT, V_INVERT, C_INVERT,
			32'h0, 32'h0, 32'h0, 6'd0, CC_GE}, 1'b0, 5'h00, 1'b0},
		'{'{OP_UPDATE, SIZE_BYTE, X_KEEP, N_KEEP, Z_KEEP, V_DEST_RES, C_COPY_X,
			32'h0, 32'h0000_0080, 32'h0000_0080, 6'd0, CC_MI}, 1'b0, 5'h00, 1'b0},
		'{'{OP_UPDATE, SizeUnused, X_CARRY, N_SIGN, Z_ZERO, V_KEEP, C_SIGNS_OR,
			32'h0, 32'h8000_0000, 32'h0, 6'd0, CC_PL}, 1'b0, 5'h00, 1'b0},
		'{'{OP_UPDATE, SIZE_LONG, X_CARRY, NRuleUnused, Z_KEEP, VRuleUnused, CRuleUnused,
			32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 6'd63, CC_VC}, 1'b0, 5'h00, 1'b0},
		'{'{OP_UPDATE, SIZE_LONG, X_CARRY, N_SIGN, Z_ZERO, V_SUB_OVF, C_BORROW,
			32'h0000_0001, 32'h0, 32'hffff_ffff, 6'd0, CC_GT}, 1'b0, 5'h00, 1'b0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  op = '0;
	logic [1:0]  size = '0;
	logic        x_rule = 1'b0;
	logic [1:0]  n_rule = '0;
	logic [1:0]  z_rule = '0;
	logic [2:0]  v_rule = '0;
	logic [3:0]  c_rule = '0;
	logic [31:0] source = '0;
	logic [31:0] dest = '0;
	logic [31:0] result_value = '0;
	logic [5:0]  shift_count = '0;
	logic [3:0]  condition = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [4:0]  flags;
	logic        condition_true;

	logic        offer_known = 1'b0;
	logic [4:0]  offer_flags = '0;
	logic        offer_cond = 1'b0;

	logic [4:0]  ccr_shadow = '0;
	ccu_result_t results_due [$];
	int          n_accepted = 0;
	int          n_checked = 0;
	int          n_errors = 0;
	int          n_updates = 0;
	int          n_loads = 0;
	int          n_tests = 0;
	int          quiet_cycles = 0;
	bit          calm_tail = 1'b0;

	cpu_condition_code_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.size(size),
		.x_rule(x_rule),
		.n_rule(n_rule),
		.z_rule(z_rule),
		.v_rule(v_rule),
		.c_rule(c_rule),
		.source(source),
		.dest(dest),
		.result_value(result_value),
		.shift_count(shift_count),
		.condition(condition),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.flags(flags),
		.condition_true(condition_true)
	);

	always #6 clk = ~clk;

	function automatic logic [4:0] flags_after(ccu_item_t it, logic [4:0] prev);
		flags_t      f;
		logic [31:0] mask;
		logic [31:0] top;
		logic [31:0] s;
		logic [31:0] d;
		logic [31:0] r;
		int unsigned msb;
		int unsigned cnt;
		logic        sm;
		logic        dm;
		logic        rm;
		logic        old_x;
		f = prev;
		old_x = f.x;
		if (it.op == OP_LOAD)
			return it.source[4:0];
		if (it.op != OP_UPDATE)
			return prev;
		case (it.size)
			SIZE_BYTE: begin
				mask = MaskByte;
				top = TopByte;
				msb = MsbByte;
			end
			SIZE_WORD: begin
				mask = MaskWord;
				top = TopWord;
				msb = MsbWord;
			end
			default: begin
				mask = MaskLong;
				top = TopLong;
				msb = MsbLong;
			end
		endcase
		cnt = it.shift_count;
		s = it.source & mask;
		d = it.dest & mask;
		r = it.result_value & mask;
		sm = |(s & top);
		dm = |(d & top);
		rm = |(r & top);
		case (it.n_rule)
			N_SIGN:   f.n = rm;
			N_INVERT: f.n = ~f.n;
			default:  ;
		endcase
		case (it.z_rule)
			Z_ZERO:   f.z = (r == 0);
			Z_INVERT: f.z = ~f.z;
			Z_STICKY: f.z = f.z & (r == 0);
			default:  ;
		endcase
		case (it.v_rule)
			V_CLEAR:    f.v = 1'b0;
			V_INVERT:   f.v = ~f.v;
			V_ADD_OVF:  f.v = (sm & dm & ~rm) | (~sm & ~dm & rm);
			V_SUB_OVF:  f.v = (~sm & dm & ~rm) | (sm & ~dm & rm);
			V_DEST_RES: f.v = dm & rm;
			default:    ;
		endcase
		case (it.c_rule)
			C_INVERT:   f.c = ~f.c;
			C_CLEAR:    f.c = 1'b0;
			C_COPY_X:   f.c = old_x;
			C_SHR_OUT:  f.c = (cnt >= 1 && cnt <= msb + 1) ? d[cnt - 1] : 1'b0;
			C_SHL_OUT:  f.c = (cnt >= 1 && cnt <= msb + 1) ? d[msb + 1 - cnt] : 1'b0;
			C_SIGNS_OR: f.c = dm | rm;
			C_BORROW:   f.c = (sm & ~dm) | (rm & ~dm) | (sm & rm);
			C_CARRY:    f.c = (sm & dm) | (~rm & dm) | (sm & ~rm);
			default:    ;
		endcase
		if (it.x_rule == X_CARRY)
			f.x = f.c;
		return f;
	endfunction

	function automatic logic branch_taken(logic [4:0] fl, logic [3:0] cc);
		flags_t f;
		f = fl;
		case (cc)
			CC_T:    return 1'b1;
			CC_F:    return 1'b0;
			CC_HI:   return ~f.c & ~f.z;
			CC_LS:   return f.c | f.z;
			CC_CC:   return ~f.c;
			CC_CS:   return f.c;
			CC_NE:   return ~f.z;
			CC_EQ:   return f.z;
			CC_VC:   return ~f.v;
			CC_VS:   return f.v;
			CC_PL:   return ~f.n;
			CC_MI:   return f.n;
			CC_GE:   return f.n == f.v;
			CC_LT:   return f.n != f.v;
			CC_GT:   return (f.n == f.v) & ~f.z;
			default: return (f.n != f.v) | f.z;
		endcase
	endfunction

	function automatic ccu_item_t random_instruction();
		ccu_item_t   it;
		logic [31:0] mask;
		int unsigned pick;
		int unsigned cnt_top;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			it.op = OP_UPDATE;
		else if (pick < 82)
			it.op = OP_TEST;
		else if (pick < 94)
			it.op = OP_LOAD;
		else
			it.op = OpUnused;
		it.size = ($urandom_range(0, 9) == 0) ? SizeUnused : 2'($urandom_range(0, 2));
		case (it.size)
			SIZE_BYTE: begin
				mask = MaskByte;
				cnt_top = 9;
			end
			SIZE_WORD: begin
				mask = MaskWord;
				cnt_top = 17;
			end
			default: begin
				mask = MaskLong;
				cnt_top = 33;
			end
		endcase
		it.x_rule = 1'($urandom_range(0, 1));
		it.n_rule = 2'($urandom_range(0, 3));
		it.z_rule = 2'($urandom_range(0, 3));
		it.v_rule = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) :
			3'($urandom_range(0, 5));
		it.c_rule = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) :
			4'($urandom_range(0, 8));
		it.source = $urandom;
		it.dest = $urandom;
		case ($urandom_range(0, 7))
			0, 1, 2: it.result_value = it.dest + it.source;
			3, 4:    it.result_value = it.dest - it.source;
			5:       it.result_value = $urandom & ~mask;
			default: it.result_value = $urandom;
		endcase
		it.shift_count = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) :
			6'($urandom_range(0, cnt_top));
		it.condition = 4'($urandom_range(0, 15));
		return it;
	endfunction

	task automatic offer_item(ccu_item_t it, logic known, logic [4:0] kf, logic kc);
		if (!calm_tail && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		{op, size, x_rule, n_rule, z_rule, v_rule, c_rule, source, dest, result_value,
			shift_count, condition} <= it;
		offer_known <= known;
		offer_flags <= kf;
		offer_cond <= kc;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Results are checked before the new transfer is predicted in the same edge.
	always @(posedge clk) begin
		ccu_item_t   seen;
		ccu_result_t due;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$display("%0t ns: result with nothing expected, flags %h cond %b",
						$time, flags, condition_true);
					n_errors++;
				end else begin
					due = results_due.pop_front();
					n_checked++;
					if (flags !== due.flags) begin
						$display("%0t ns: flags mismatch, expected %h, actual %h",
							$time, due.flags, flags);
						n_errors++;
					end
					if (condition_true !== due.cond) begin
						$display("%0t ns: condition mismatch, expected %b, actual %b",
							$time, due.cond, condition_true);
						n_errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				seen = {op, size, x_rule, n_rule, z_rule, v_rule, c_rule, source, dest,
					result_value, shift_count, condition};
				ccr_shadow = flags_after(seen, ccr_shadow);
				if (offer_known)
					due = '{offer_flags, offer_cond};
				else
					due = '{ccr_shadow, branch_taken(ccr_shadow, seen.condition)};
				results_due.push_back(due);
				n_accepted++;
				if (seen.op == OP_UPDATE)
					n_updates++;
				else if (seen.op == OP_LOAD)
					n_loads++;
				else
					n_tests++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WatchdogLimit) begin
				$display("FAILURE");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// The long hold lets both pipeline registers fill so that input ready drops.
	initial begin
		int gap_left;
		int hold_left;
		bit held;
		gap_left = 0;
		hold_left = 0;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!held && n_accepted >= StallAfter) begin
				held = 1'b1;
				hold_left = StallCycles - 1;
				out_ready <= 1'b0;
			end else if (calm_tail) begin
				out_ready <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				gap_left = $urandom_range(1, 15) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		ccu_item_t it;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int k = 0; k < DirectedCount; k++)
			offer_item(DirectedSteps[k].item, DirectedSteps[k].known,
				DirectedSteps[k].flags, DirectedSteps[k].cond);
		for (int k = 0; k < RandomCount; k++) begin
			if (k >= RandomCount - CalmTail)
				calm_tail = 1'b1;
			it = random_instruction();
			offer_item(it, 1'b0, 5'h00, 1'b0);
		end
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("Checked %0d results from %0d transfers: %0d updates, %0d loads, %0d tests.",
			n_checked, n_accepted, n_updates, n_loads, n_tests);
		$display("Random rule, size and shift mixes ran with idle bursts and one long stall.");
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
